FILE: rtl/nefs_pkg.sv
package nefs_pkg;

	// request, result and internal datapath widths
	localparam int REQ_W       = 31;
	localparam int VALUE_WIDTH = 32;
	localparam int OUT_W       = 32;
	localparam int DW          = 35;

	// microprogram size and step labels
	localparam int NSTEPS = 9;
	localparam int PC_W   = $clog2(NSTEPS);

	localparam logic [PC_W-1:0] ST_INIT    = PC_W'(0);
	localparam logic [PC_W-1:0] ST_TEST_P5 = PC_W'(1);
	localparam logic [PC_W-1:0] ST_SET_P3  = PC_W'(2);
	localparam logic [PC_W-1:0] ST_TEST_P3 = PC_W'(3);
	localparam logic [PC_W-1:0] ST_SET_V   = PC_W'(4);
	localparam logic [PC_W-1:0] ST_DBL     = PC_W'(5);
	localparam logic [PC_W-1:0] ST_UPD     = PC_W'(6);
	localparam logic [PC_W-1:0] ST_NEXT_P5 = PC_W'(7);
	localparam logic [PC_W-1:0] ST_DONE    = PC_W'(8);

	// result saturation bound
	localparam logic [DW-1:0] VMAX = DW'((64'd1 << VALUE_WIDTH) - 64'd1);

	typedef enum logic [2:0] {
		COND_NEVER,
		COND_ALWAYS,
		COND_P5_GT_LIM,
		COND_P3_GT_LIM,
		COND_V_LT_REQ
	} cond_t;

	typedef struct packed {
		cond_t           cond;
		logic [PC_W-1:0] target;
		logic            init;
		logic            ld_p3;
		logic            ld_v;
		logic            dbl_v;
		logic            upd_best;
		logic            mul3;
		logic            mul5;
		logic            done;
	} ctrl_word_t;

	typedef struct packed {
		logic p5_gt_lim;
		logic p3_gt_lim;
		logic v_lt_req;
	} dp_flags_t;

endpackage

FILE: rtl/nefs_ucode.sv
module nefs_ucode (
	input  logic [nefs_pkg::PC_W-1:0] pc,
	output nefs_pkg::ctrl_word_t      cw
);
	import nefs_pkg::*;

	always_comb begin
		cw        = '0;
		cw.cond   = COND_NEVER;
		cw.target = ST_INIT;
		case (pc)
			ST_INIT: begin
				cw.init = 1'b1;
			end
			ST_TEST_P5: begin
				cw.cond   = COND_P5_GT_LIM;
				cw.target = ST_DONE;
			end
			ST_SET_P3: begin
				cw.ld_p3 = 1'b1;
			end
			ST_TEST_P3: begin
				cw.cond   = COND_P3_GT_LIM;
				cw.target = ST_NEXT_P5;
			end
			ST_SET_V: begin
				cw.ld_v = 1'b1;
			end
			ST_DBL: begin
				cw.cond   = COND_V_LT_REQ;
				cw.target = ST_DBL;
				cw.dbl_v  = 1'b1;
			end
			ST_UPD: begin
				cw.cond     = COND_ALWAYS;
				cw.target   = ST_TEST_P3;
				cw.upd_best = 1'b1;
				cw.mul3     = 1'b1;
			end
			ST_NEXT_P5: begin
				cw.cond   = COND_ALWAYS;
				cw.target = ST_TEST_P5;
				cw.mul5   = 1'b1;
			end
			ST_DONE: begin
				cw.done = 1'b1;
			end
			default: begin
				cw.cond   = COND_ALWAYS;
				cw.target = ST_DONE;
			end
		endcase
	end

endmodule

FILE: rtl/nefs_seq.sv
module nefs_seq (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  nefs_pkg::ctrl_word_t      rom_cw,
	input  nefs_pkg::dp_flags_t       flags,
	output logic [nefs_pkg::PC_W-1:0] pc,
	output nefs_pkg::ctrl_word_t      exec_cw,
	output logic                      busy,
	output logic                      done
);
	import nefs_pkg::*;

	logic [PC_W-1:0] pc_q;
	logic            active_q;
	logic            done_q;
	logic            taken;

	always_comb begin
		case (rom_cw.cond)
			COND_NEVER:     taken = 1'b0;
			COND_ALWAYS:    taken = 1'b1;
			COND_P5_GT_LIM: taken = flags.p5_gt_lim;
			COND_P3_GT_LIM: taken = flags.p3_gt_lim;
			COND_V_LT_REQ:  taken = flags.v_lt_req;
			default:        taken = 1'b0;
		endcase
	end

	// idle steps issue a no-op word
	assign exec_cw = active_q ? rom_cw : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q     <= ST_INIT;
			active_q <= 1'b0;
			done_q   <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (!active_q) begin
				if (start) begin
					active_q <= 1'b1;
					pc_q     <= ST_INIT;
				end
			end else if (rom_cw.done) begin
				active_q <= 1'b0;
				done_q   <= 1'b1;
				pc_q     <= ST_INIT;
			end else if (taken) begin
				pc_q <= rom_cw.target;
			end else begin
				pc_q <= pc_q + PC_W'(1);
			end
		end
	end

	assign pc   = pc_q;
	assign busy = active_q;
	assign done = done_q;

endmodule

FILE: rtl/nefs_dp.sv
module nefs_dp (
	input  logic                       clk,
	input  logic                       load,
	input  logic [nefs_pkg::REQ_W-1:0] size_request,
	input  nefs_pkg::ctrl_word_t       cw,
	output nefs_pkg::dp_flags_t        flags,
	output logic [nefs_pkg::OUT_W-1:0] smooth_size
);
	import nefs_pkg::*;

	logic [REQ_W-1:0] req_q;
	logic [DW-1:0]    lim_q;
	logic [DW-1:0]    p5_q;
	logic [DW-1:0]    p3_q;
	logic [DW-1:0]    v_q;
	logic [DW-1:0]    best_q;
	logic             have_q;
	logic [OUT_W-1:0] out_q;
	logic [DW-1:0]    req_ext;

	assign req_ext = DW'(req_q);

	assign flags.p5_gt_lim = p5_q > lim_q;
	assign flags.p3_gt_lim = p3_q > lim_q;
	assign flags.v_lt_req  = v_q < req_ext;

	always_ff @(posedge clk) begin
		if (load)
			req_q <= size_request;
		if (cw.init) begin
			// no answer is above twice the request (floored at two)
			lim_q  <= (req_q < REQ_W'(2)) ? DW'(4) : (req_ext << 1);
			p5_q   <= DW'(1);
			have_q <= 1'b0;
			best_q <= '0;
		end
		if (cw.ld_p3)
			p3_q <= p5_q;
		if (cw.ld_v)
			v_q <= p3_q << 1;
		if (cw.dbl_v && flags.v_lt_req)
			v_q <= v_q << 1;
		if (cw.upd_best && (!have_q || v_q < best_q)) begin
			best_q <= v_q;
			have_q <= 1'b1;
		end
		if (cw.mul3)
			p3_q <= (p3_q << 1) + p3_q;
		if (cw.mul5)
			p5_q <= (p5_q << 2) + p5_q;
		if (cw.done)
			out_q <= (best_q > VMAX) ? OUT_W'(VMAX) : OUT_W'(best_q);
	end

	assign smooth_size = out_q;

endmodule

FILE: rtl/next_even_five_smooth.sv
// next_even_five_smooth: smallest even 2-3-5 smooth size not below a request
//
// command channel: drive size_request and raise start; the transfer happens
// at the rising edge where start is high and busy is low. busy stays high
// while the search runs, and no new command is taken until it drops.
// result channel: smooth_size is valid for exactly one cycle while done is
// high; that cycle's closing edge is the transfer. the receiver cannot stall,
// so it must take the value then. busy is already low in the done cycle, so
// the next command may be issued while the result is still on the port.
// search: a microprogram walks each power of five up to twice the request
// and, under it, each power-of-three multiple up to the same bound; each
// such candidate is doubled, doubled again while below the request and kept
// as the running minimum if smaller. after the last power of five the done
// step runs; done rises in the cycle after it. one item at a time.
// reset: arst_n clears the step counter, busy and done; the datapath
// registers are not reset and are reloaded by every command.
module next_even_five_smooth (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  logic [nefs_pkg::REQ_W-1:0] size_request,
	output logic                       done,
	output logic [nefs_pkg::OUT_W-1:0] smooth_size
);
	import nefs_pkg::*;

	logic [PC_W-1:0] pc;
	ctrl_word_t      rom_cw;
	ctrl_word_t      exec_cw;
	dp_flags_t       flags;
	logic            load;

	// capture the request on the command transfer
	assign load = start && !busy;

	// control store: one word per microprogram step
	nefs_ucode u_ucode (
		.pc (pc),
		.cw (rom_cw)
	);

	// step counter with conditional jumps on datapath flags
	nefs_seq u_seq (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.rom_cw  (rom_cw),
		.flags   (flags),
		.pc      (pc),
		.exec_cw (exec_cw),
		.busy    (busy),
		.done    (done)
	);

	// candidate generator, doubling loop, running minimum and result register
	nefs_dp u_dp (
		.clk          (clk),
		.load         (load),
		.size_request (size_request),
		.cw           (exec_cw),
		.flags        (flags),
		.smooth_size  (smooth_size)
	);

	// a command transfer always starts the search
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("busy not raised after command transfer");

	// the result strobe lasts a single cycle
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("done held longer than one cycle");

	// done only follows the end of a running search
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy) && !busy)
		else $error("done without a finished search");

	// every result is even and at least two
	a_result_even: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !smooth_size[0] && (smooth_size != '0))
		else $error("result not an even nonzero size");

endmodule
